// ----- design/nrld_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrld_pkg
// Types and phase codes shared by the nibble run-length decoder modules,
// and the per-nibble decode step used by nrld_decode.
// ----------------------------------------------------------------------------
package nrld_pkg;

  localparam logic [3:0] NIB_ESC = 4'hF;
  localparam logic [8:0] RUN_BIAS = 9'd4;

  // Escape sequence phase
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_ESC_V   = 3'd2,
    PH_ESC2    = 3'd3,
    PH_ESC2_H  = 3'd4,
    PH_ESC2_HL = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] fill_value;
    logic [8:0] run_length;
    logic       frame_end;
    logic       truncated;
  } out_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] held_value;
    logic [3:0] held_count_high;
    logic [3:0] held_count_low;
  } dec_state_t;

  // Result of one nibble step
  typedef struct packed {
    dec_state_t state;
    logic       emit;
    out_item_t  item;
  } feed_t;

  // Decoded byte handed to the result buffer
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
  } dec_out_t;

  localparam dec_state_t STATE_RESET = '{phase: PH_IDLE, held_value: 4'd0,
                                         held_count_high: 4'd0,
                                         held_count_low: 4'd0};

  // One nibble through the escape state machine
  function automatic feed_t nib_feed(dec_state_t st, logic [3:0] nib);
    feed_t f;
    f       = '0;
    f.state = st;
    unique case (st.phase)
      PH_ESC: begin
        if (nib != NIB_ESC) begin
          f.state.held_value = nib;
          f.state.phase      = PH_ESC_V;
        end else begin
          f.state.phase = PH_ESC2;
        end
      end
      PH_ESC_V: begin
        f.emit            = 1'b1;
        f.item.fill_value = st.held_value;
        f.item.run_length = {5'd0, nib} + RUN_BIAS;
        f.state.phase     = PH_IDLE;
      end
      PH_ESC2: begin
        f.state.held_count_high = nib;
        f.state.phase           = PH_ESC2_H;
      end
      PH_ESC2_H: begin
        f.state.held_count_low = nib;
        f.state.phase          = PH_ESC2_HL;
      end
      PH_ESC2_HL: begin
        f.emit            = 1'b1;
        f.item.fill_value = nib;
        f.item.run_length = {1'b0, st.held_count_high, st.held_count_low} + RUN_BIAS;
        f.state.phase     = PH_IDLE;
      end
      default: begin
        if (nib == NIB_ESC) begin
          f.state.phase = PH_ESC;
        end else begin
          f.emit            = 1'b1;
          f.item.fill_value = nib;
          f.item.run_length = 9'd1;
          f.state.phase     = PH_IDLE;
        end
      end
    endcase
    return f;
  endfunction

endpackage

// ----- design/nrld_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrld_decode
// Decodes both nibbles of one byte against the current escape state and
// builds up to two results, including the end-of-frame marker.
// ----------------------------------------------------------------------------
module nrld_decode import nrld_pkg::*; (
  input  dec_state_t state,
  input  in_item_t   item,
  output dec_state_t state_next,
  output dec_out_t   dec
);

  feed_t      f_hi;
  feed_t      f_lo;
  logic       mid;
  logic       marker;
  out_item_t  mark_item;
  logic [1:0] run_cnt;

  // High nibble first, then low nibble
  always_comb begin
    f_hi = nib_feed(state, item.data_byte[7:4]);
    f_lo = nib_feed(f_hi.state, item.data_byte[3:0]);
  end

  // Pack the runs, append the end marker and flag the frame end
  always_comb begin
    run_cnt             = {1'b0, f_hi.emit} + {1'b0, f_lo.emit};
    mid                 = (f_lo.state.phase != PH_IDLE);
    marker              = item.last_byte && (mid || (run_cnt == 2'd0));
    mark_item           = '0;
    mark_item.frame_end = 1'b1;
    mark_item.truncated = mid;

    dec    = '0;
    dec.r0 = f_hi.emit ? f_hi.item : f_lo.item;
    dec.r1 = f_lo.item;
    if (marker) begin
      if (run_cnt == 2'd0) begin
        dec.r0 = mark_item;
      end else begin
        dec.r1 = mark_item;
      end
    end
    dec.count = run_cnt + {1'b0, marker};

    // Last result of the last byte carries frame_end
    if (item.last_byte) begin
      if (dec.count == 2'd1) begin
        dec.r0.frame_end = 1'b1;
      end else begin
        dec.r1.frame_end = 1'b1;
      end
    end

    state_next = item.last_byte ? STATE_RESET : f_lo.state;
  end

endmodule

// ----- design/nrld_result_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrld_result_buf
// Two-entry result register. Loads all results of one byte at once and
// drains them one per transfer.
// ----------------------------------------------------------------------------
module nrld_result_buf import nrld_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  dec_out_t  dec,
  output logic      can_load,
  output logic      run_valid,
  input  logic      run_ready,
  output out_item_t run_item
);

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  out_item_t  slot0;
  out_item_t  slot1;
  logic       pop;

  assign run_valid = (cnt != 2'd0);
  assign run_item  = slot0;
  assign pop       = run_valid && run_ready;
  // Free after this cycle: empty, or last entry leaving now
  assign can_load  = (cnt == 2'd0) || ((cnt == 2'd1) && run_ready);

  always_comb begin
    cnt_next = cnt;
    if (load) begin
      cnt_next = dec.count;
    end else if (pop) begin
      cnt_next = cnt - 2'd1;
    end
  end

  // Count in reset; payload slots unreset
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= dec.r0;
      slot1 <= dec.r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  // Never more than two results held
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("result count out of range");

  // Loading only when the buffer is empty or drains this cycle
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> ((cnt == 2'd0) || ((cnt == 2'd1) && pop)))
    else $error("results overwritten");

  // Second result moves to the head after the first transfer
  a_shift: assert property (@(posedge clk) disable iff (rst)
    (pop && !load && (cnt == 2'd2)) |=> (run_item == $past(slot1)))
    else $error("second result lost");

endmodule

// ----- design/nibble_run_length_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_run_length_decoder
// Nibble run-length decoder: frame bytes in, (value, run length) results out.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded in the cycle it is accepted and its results
// (zero, one or two) land in a two-entry result register, one result leaving
// per output transfer. A byte is taken every cycle while each byte yields at
// most one result and the output side keeps up; a byte that yields two
// results stalls the next byte until one has left; throughput is set by the
// single result drained per cycle. byte_ready follows run_ready within the
// same cycle. A byte marked last closes the frame: its final result has
// frame_end set, an escape left open raises truncated on a zero-length end
// marker, and the decoder returns to idle for the next frame.
// ----------------------------------------------------------------------------
module nibble_run_length_decoder import nrld_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_item_t  byte_item,
  output logic      run_valid,
  input  logic      run_ready,
  output out_item_t run_item
);

  dec_state_t state;
  dec_state_t state_next;
  dec_out_t   dec;
  logic       load;
  logic       can_load;

  assign byte_ready = can_load;
  assign load       = byte_valid && can_load;

  // Escape state register, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (load) begin
      state <= state_next;
    end
  end

  nrld_decode u_decode (
    .state      (state),
    .item       (byte_item),
    .state_next (state_next),
    .dec        (dec)
  );

  nrld_result_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .dec       (dec),
    .can_load  (can_load),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run_item  (run_item)
  );

  // A last byte always leaves the decoder idle
  a_frame_idle: assert property (@(posedge clk) disable iff (rst)
    (load && byte_item.last_byte) |=> (state.phase == PH_IDLE))
    else $error("decoder not idle after frame end");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nibble run-length decoder.
// ----------------------------------------------------------------------------
// Frame bytes go in through a queue-fed driver with random idle bursts.
// Each accepted byte is decoded by a local nibble decoder, which queues the
// runs the block should produce. A monitor compares every output transfer,
// field by field, against the oldest queued run. The stimulus is a short
// directed set (extreme runs, escapes that cross bytes, truncated frames),
// then random frames built from pixels and short and long escapes, with
// some raw noise bytes and cut-off frames mixed in. The output side is held
// off once for a long stretch so that the block backs up its input.
// ----------------------------------------------------------------------------
module tb;
  import nrld_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_item_t  byte_item = '0;
  logic      run_valid;
  logic      run_ready = 1'b0;
  out_item_t run_item;

  // Local decoder state
  phase_t     dec_phase = PH_IDLE;
  logic [3:0] dec_value = '0;
  logic [3:0] dec_cnt_hi = '0;
  logic [3:0] dec_cnt_lo = '0;

  in_item_t  byte_queue[$];
  out_item_t run_expect[$];
  int        bytes_pushed = 0;
  int        bytes_accepted = 0;
  int        mismatch_count = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  logic      calm = 1'b0;

  nibble_run_length_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .run_valid  (run_valid),
    .run_ready  (run_ready),
    .run_item   (run_item)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_item_t make_run(logic [3:0] value, logic [8:0] len);
    out_item_t r;
    r            = '0;
    r.fill_value = value;
    r.run_length = len;
    return r;
  endfunction

  // Decode one accepted byte, high nibble first, and queue its runs
  task automatic decode_byte(input in_item_t it);
    out_item_t  runs[3];
    int         n;
    logic [3:0] nib;
    bit         in_escape;
    n = 0;
    for (int k = 0; k < 2; k++) begin
      nib = (k == 0) ? it.data_byte[7:4] : it.data_byte[3:0];
      case (dec_phase)
        PH_ESC: begin
          if (nib != NIB_ESC) begin
            dec_value = nib;
            dec_phase = PH_ESC_V;
          end else begin
            dec_phase = PH_ESC2;
          end
        end
        PH_ESC_V: begin
          runs[n] = make_run(dec_value, {5'd0, nib} + RUN_BIAS);
          n++;
          dec_phase = PH_IDLE;
        end
        PH_ESC2: begin
          dec_cnt_hi = nib;
          dec_phase  = PH_ESC2_H;
        end
        PH_ESC2_H: begin
          dec_cnt_lo = nib;
          dec_phase  = PH_ESC2_HL;
        end
        PH_ESC2_HL: begin
          runs[n] = make_run(nib, {1'b0, dec_cnt_hi, dec_cnt_lo} + RUN_BIAS);
          n++;
          dec_phase = PH_IDLE;
        end
        default: begin
          if (nib == NIB_ESC) begin
            dec_phase = PH_ESC;
          end else begin
            runs[n] = make_run(nib, 9'd1);
            n++;
            dec_phase = PH_IDLE;
          end
        end
      endcase
    end
    // Frame close: end marker when an escape is open or nothing came out
    if (it.last_byte) begin
      in_escape = (dec_phase != PH_IDLE);
      if (in_escape || n == 0) begin
        runs[n]           = make_run(4'd0, 9'd0);
        runs[n].truncated = in_escape;
        n++;
      end
      runs[n-1].frame_end = 1'b1;
      dec_phase  = PH_IDLE;
      dec_value  = '0;
      dec_cnt_hi = '0;
      dec_cnt_lo = '0;
    end
    for (int i = 0; i < n; i++) run_expect.push_back(runs[i]);
  endtask

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic push_byte(input logic [7:0] data, input logic last);
    in_item_t b;
    b.data_byte = data;
    b.last_byte = last;
    byte_queue.push_back(b);
    bytes_pushed++;
  endtask

  // One random frame: mostly well-formed tokens, some noise, some cut short
  task automatic add_frame();
    logic [3:0] nibs[$];
    int         roll;
    int         cut;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom), $urandom_range(0, 5) == 0);
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 2))
        0: nibs.push_back(4'($urandom_range(0, 14)));
        1: begin
          nibs.push_back(NIB_ESC);
          nibs.push_back(4'($urandom_range(0, 14)));
          nibs.push_back(4'($urandom_range(0, 15)));
        end
        default: begin
          nibs.push_back(NIB_ESC);
          nibs.push_back(NIB_ESC);
          repeat (3) nibs.push_back(4'($urandom_range(0, 15)));
        end
      endcase
    end
    // Broken frame: drop up to three nibbles from the end
    if (roll == 1 && nibs.size() > 1) begin
      cut = $urandom_range(1, (nibs.size() > 4) ? 3 : nibs.size() - 1);
      repeat (cut) void'(nibs.pop_back());
    end
    if (nibs.size() % 2 != 0) nibs.push_back(4'($urandom_range(0, 14)));
    for (int i = 0; i < nibs.size(); i += 2)
      push_byte({nibs[i], nibs[i+1]}, (i + 2) >= nibs.size());
  endtask

  task automatic fill_random(input int count);
    int start;
    start = bytes_pushed;
    while (bytes_pushed - start < count) add_frame();
  endtask

  // Sender pause: wait until every queued byte is in and every run is out
  task automatic wait_idle();
    do @(posedge clk);
    while (byte_queue.size() != 0 || byte_valid || run_expect.size() != 0);
  endtask

  // Input driver with random idle bursts
  always @(posedge clk) begin : driver
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        decode_byte(byte_item);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!byte_valid || byte_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 6);
          byte_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          byte_item  <= byte_queue.pop_front();
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random stalls plus one long hold-off
  always @(posedge clk) begin : receiver
    if (rst) begin
      run_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      run_ready <= 1'b0;
    end else if (!hold_done && bytes_accepted >= 150) begin
      hold_done = 1'b1;
      hold_left = 79;
      run_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      run_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      run_ready <= 1'b0;
    end else begin
      run_ready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expected run
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst && run_valid && run_ready) begin
      if (run_expect.size() == 0) begin
        flag_error($sformatf("unexpected run: value %0d length %0d end %0b trunc %0b",
                             run_item.fill_value, run_item.run_length,
                             run_item.frame_end, run_item.truncated));
      end else begin
        want = run_expect.pop_front();
        if (run_item.fill_value !== want.fill_value ||
            run_item.run_length !== want.run_length ||
            run_item.frame_end !== want.frame_end ||
            run_item.truncated !== want.truncated) begin
          flag_error($sformatf({"run mismatch: expected value %0d length %0d end %0b ",
                                "trunc %0b, got value %0d length %0d end %0b trunc %0b"},
                               want.fill_value, want.run_length, want.frame_end,
                               want.truncated, run_item.fill_value, run_item.run_length,
                               run_item.frame_end, run_item.truncated));
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Pixels at both ends of the value range
    push_byte(8'h0E, 1'b0);
    push_byte(8'h12, 1'b1);
    // Shortest and longest short runs
    push_byte(8'hF3, 1'b0);
    push_byte(8'h05, 1'b1);
    push_byte(8'hFE, 1'b0);
    push_byte(8'hF1, 1'b1);
    // Longest long run, value 15
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hF2, 1'b1);
    // Shortest long run, value 0
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h07, 1'b1);
    // Truncated frames, each ending with an escape still open
    push_byte(8'h1F, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hF3, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5F, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b1);
    // Escapes crossing byte boundaries, then a run and a truncation together
    push_byte(8'h8F, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'hF6, 1'b0);
    push_byte(8'h2F, 1'b1);
    wait_idle();

    fill_random(300);
    wait_idle();
    fill_random(300);
    wait_idle();
    // Last part runs with no idling on either side
    calm <= 1'b1;
    fill_random(100);
    wait_idle();
    repeat (20) @(posedge clk);

    if (run_expect.size() != 0)
      flag_error($sformatf("%0d expected runs never came out", run_expect.size()));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- nibble_run_length_decoder.f -----
design/nrld_pkg.sv
design/nrld_decode.sv
design/nrld_result_buf.sv
design/nibble_run_length_decoder.sv
tb/tb.sv
